[hw/rtl/x86enc_pkg.sv]
// Shared types and encoding constants for the x86-64 instruction encoder.
// Depends on nothing; every other file of the block uses it by scoped names.
package x86enc_pkg;

  // Longest instruction the encoder can produce, in bytes.
  localparam int MaxBytes = 12;
  localparam int LenW     = $clog2(MaxBytes + 1);
  localparam int IdxW     = $clog2(MaxBytes);

  // Command codes.
  localparam logic [3:0] CMD_ADD     = 4'd0;
  localparam logic [3:0] CMD_SUB     = 4'd1;
  localparam logic [3:0] CMD_MUL     = 4'd2;
  localparam logic [3:0] CMD_DIV     = 4'd3;
  localparam logic [3:0] CMD_MOV     = 4'd4;
  localparam logic [3:0] CMD_CMP     = 4'd5;
  localparam logic [3:0] CMD_SETCC   = 4'd6;
  localparam logic [3:0] CMD_JMP     = 4'd7;
  localparam logic [3:0] CMD_JCC     = 4'd8;
  localparam logic [3:0] CMD_CALL    = 4'd9;
  localparam logic [3:0] CMD_RET     = 4'd10;
  localparam logic [3:0] CMD_ENTER   = 4'd11;
  localparam logic [3:0] CMD_LEAVE   = 4'd12;
  localparam logic [3:0] CMD_PUSH    = 4'd13;
  localparam logic [3:0] CMD_POP     = 4'd14;
  localparam logic [3:0] CMD_SYSCALL = 4'd15;

  // Operand kinds.
  localparam logic [2:0] KIND_REG     = 3'd0;
  localparam logic [2:0] KIND_IMM     = 3'd1;
  localparam logic [2:0] KIND_ABS     = 3'd2;
  localparam logic [2:0] KIND_RIP     = 3'd3;
  localparam logic [2:0] KIND_REGDISP = 3'd4;

  // Opcode bytes and fixed fields.
  localparam logic [7:0] OPC_GRP1_IMM = 8'h81;  // 1000 000w
  localparam logic [7:0] OPC_ADD      = 8'h01;  // 0000 00dw
  localparam logic [7:0] OPC_SUB      = 8'h29;
  localparam logic [7:0] OPC_MOV      = 8'h89;  // 1000 10dw
  localparam logic [7:0] OPC_CMP      = 8'h39;  // 0011 10dw
  localparam logic [7:0] OPC_GRP3     = 8'hF7;  // 1111 011w
  localparam logic [7:0] OPC_GRP5     = 8'hFF;  // 1111 1111
  localparam logic [7:0] OPC_POP_RM   = 8'h8F;
  localparam logic [7:0] OPC_ESC      = 8'h0F;
  localparam logic [7:0] OPC_SETCC    = 8'h90;  // second byte 1001 tttt
  localparam logic [7:0] OPC_JCC      = 8'h80;
  localparam logic [7:0] OPC_JMP_REL  = 8'hE9;
  localparam logic [7:0] OPC_CALL_REL = 8'hE8;
  localparam logic [7:0] OPC_MOV_IMM  = 8'hB8;
  localparam logic [7:0] OPC_RET      = 8'hC3;
  localparam logic [7:0] OPC_RET_IMM  = 8'hC2;
  localparam logic [7:0] OPC_ENTER    = 8'hC8;
  localparam logic [7:0] OPC_LEAVE    = 8'hC9;
  localparam logic [7:0] OPC_PUSH_IMM = 8'h68;
  localparam logic [7:0] OPC_SYSCALL  = 8'h05;
  localparam logic [7:0] REX_BASE     = 8'h40;
  localparam logic [7:0] REX_W        = 8'h48;
  localparam logic [7:0] MODRM_CMP_RI = 8'hF8;
  localparam logic [7:0] SIB_ABS      = 8'h25;
  localparam logic [7:0] SIB_RSP      = 8'h24;
  localparam logic [2:0] RM_SIB       = 3'b100;
  localparam logic [2:0] RM_RIP       = 3'b101;

  // ModRM reg-field opcode extensions.
  localparam logic [3:0] EXT_ADD  = 4'd0;
  localparam logic [3:0] EXT_SUB  = 4'd5;
  localparam logic [3:0] EXT_MUL  = 4'd4;
  localparam logic [3:0] EXT_DIV  = 4'd6;
  localparam logic [3:0] EXT_JMP  = 4'd4;
  localparam logic [3:0] EXT_CALL = 4'd2;
  localparam logic [3:0] EXT_PUSH = 4'd6;
  localparam logic [3:0] EXT_ZERO = 4'd0;

  // One instruction request.
  typedef struct packed {
    logic [3:0]         command;
    logic [2:0]         dest_kind;
    logic [3:0]         dest_reg;
    logic signed [31:0] dest_disp;
    logic [2:0]         src_kind;
    logic [3:0]         src_reg;
    logic signed [31:0] src_disp;
    logic signed [63:0] immediate;
    logic [3:0]         cond_code;
    logic signed [31:0] branch_disp;
    logic [15:0]        frame_size;
    logic [7:0]         nest_level;
  } req_t;

  // One emitted code byte.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       error;
  } rsp_t;

  // Fully encoded instruction handed from the encoder to the byte serializer.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
    logic                     err;
  } enc_t;

endpackage

[hw/rtl/x86enc_core.sv]
// Combinational encoder: turns one registered request into its byte image.
// Depends on x86enc_pkg for the request and encoded-instruction types.
module x86enc_core (
  input  x86enc_pkg::req_t req,
  output x86enc_pkg::enc_t enc
);

  // Instruction image in four segments: head (REX and opcodes), ModRM/SIB,
  // disp32 and a tail (immediate or enter operands).
  logic [2:0][7:0] hd;
  logic [1:0]      hcnt;
  logic [1:0][7:0] md;
  logic [1:0]      mcnt;
  logic            dsp_en;
  logic [31:0]     dsp;
  logic [7:0][7:0] tl;
  logic [3:0]      tcnt;
  logic            err;

  always_comb begin
    logic        use_rm;
    logic        do_two;
    logic        fixed;
    logic        force_rex;
    logic [3:0]  regf;
    logic [2:0]  rm_kind;
    logic [3:0]  rm_reg;
    logic [31:0] rm_disp;
    logic [7:0]  opc0;
    logic [7:0]  opc1;
    logic        two_opc;
    logic [7:0]  base;
    logic [1:0]  mod;
    logic [2:0]  rmf;
    logic        rb;
    logic        has_sib;
    logic [7:0]  sib;
    logic        has_rex;
    logic [7:0]  rex;

    hd        = '0;
    hcnt      = '0;
    md        = '0;
    mcnt      = '0;
    dsp_en    = 1'b0;
    dsp       = '0;
    tl        = '0;
    tcnt      = '0;
    err       = 1'b0;
    use_rm    = 1'b0;
    do_two    = 1'b0;
    fixed     = 1'b0;
    force_rex = 1'b0;
    regf      = '0;
    rm_kind   = req.dest_kind;
    rm_reg    = req.dest_reg;
    rm_disp   = req.dest_disp;
    opc0      = '0;
    opc1      = '0;
    two_opc   = 1'b0;
    base      = '0;
    mod       = '0;
    rmf       = '0;
    rb        = 1'b0;
    has_sib   = 1'b0;
    sib       = '0;
    has_rex   = 1'b0;
    rex       = '0;

    case (req.command)
      x86enc_pkg::CMD_ADD, x86enc_pkg::CMD_SUB: begin
        if (req.src_kind == x86enc_pkg::KIND_IMM) begin
          use_rm = 1'b1;
          regf   = (req.command == x86enc_pkg::CMD_ADD) ? x86enc_pkg::EXT_ADD
                                                        : x86enc_pkg::EXT_SUB;
          opc0   = x86enc_pkg::OPC_GRP1_IMM;
          for (int k = 0; k < 4; k++) tl[k] = req.immediate[8*k +: 8];
          tcnt   = 4'd4;
        end else begin
          do_two = 1'b1;
          base   = (req.command == x86enc_pkg::CMD_ADD) ? x86enc_pkg::OPC_ADD
                                                        : x86enc_pkg::OPC_SUB;
        end
      end
      x86enc_pkg::CMD_MUL, x86enc_pkg::CMD_DIV: begin
        use_rm = 1'b1;
        regf   = (req.command == x86enc_pkg::CMD_MUL) ? x86enc_pkg::EXT_MUL
                                                      : x86enc_pkg::EXT_DIV;
        opc0   = x86enc_pkg::OPC_GRP3;
      end
      x86enc_pkg::CMD_MOV: begin
        if (req.src_kind == x86enc_pkg::KIND_IMM) begin
          if (req.dest_kind == x86enc_pkg::KIND_REG) begin
            hd[0] = x86enc_pkg::REX_W | {7'd0, req.dest_reg[3]};
            hd[1] = x86enc_pkg::OPC_MOV_IMM | {5'd0, req.dest_reg[2:0]};
            hcnt  = 2'd2;
            for (int k = 0; k < 8; k++) tl[k] = req.immediate[8*k +: 8];
            tcnt  = 4'd8;
          end else begin
            err = 1'b1;
          end
        end else begin
          do_two = 1'b1;
          base   = x86enc_pkg::OPC_MOV;
        end
      end
      x86enc_pkg::CMD_CMP: begin
        if (req.dest_kind == x86enc_pkg::KIND_REG &&
            req.src_kind == x86enc_pkg::KIND_IMM) begin
          hd[0] = x86enc_pkg::REX_W | {7'd0, req.dest_reg[3]};
          hd[1] = x86enc_pkg::OPC_GRP1_IMM;
          hcnt  = 2'd2;
          md[0] = x86enc_pkg::MODRM_CMP_RI | {5'd0, req.dest_reg[2:0]};
          mcnt  = 2'd1;
          for (int k = 0; k < 4; k++) tl[k] = req.immediate[8*k +: 8];
          tcnt  = 4'd4;
        end else begin
          do_two = 1'b1;
          base   = x86enc_pkg::OPC_CMP;
        end
      end
      x86enc_pkg::CMD_SETCC: begin
        use_rm    = 1'b1;
        fixed     = 1'b1;
        force_rex = 1'b1;
        regf      = x86enc_pkg::EXT_ZERO;
        opc0      = x86enc_pkg::OPC_ESC;
        opc1      = x86enc_pkg::OPC_SETCC | {4'd0, req.cond_code};
        two_opc   = 1'b1;
      end
      x86enc_pkg::CMD_JMP, x86enc_pkg::CMD_CALL: begin
        if (req.dest_kind == x86enc_pkg::KIND_RIP) begin
          hd[0]  = (req.command == x86enc_pkg::CMD_JMP) ? x86enc_pkg::OPC_JMP_REL
                                                        : x86enc_pkg::OPC_CALL_REL;
          hcnt   = 2'd1;
          dsp_en = 1'b1;
          dsp    = req.dest_disp;
        end else begin
          use_rm = 1'b1;
          fixed  = 1'b1;
          regf   = (req.command == x86enc_pkg::CMD_JMP) ? x86enc_pkg::EXT_JMP
                                                        : x86enc_pkg::EXT_CALL;
          opc0   = x86enc_pkg::OPC_GRP5;
        end
      end
      x86enc_pkg::CMD_JCC: begin
        hd[0]  = x86enc_pkg::OPC_ESC;
        hd[1]  = x86enc_pkg::OPC_JCC | {4'd0, req.cond_code};
        hcnt   = 2'd2;
        dsp_en = 1'b1;
        dsp    = req.branch_disp;
      end
      x86enc_pkg::CMD_RET: begin
        hcnt = 2'd1;
        if (req.frame_size == 16'd0) begin
          hd[0] = x86enc_pkg::OPC_RET;
        end else begin
          hd[0] = x86enc_pkg::OPC_RET_IMM;
          tl[0] = req.frame_size[7:0];
          tl[1] = req.frame_size[15:8];
          tcnt  = 4'd2;
        end
      end
      x86enc_pkg::CMD_ENTER: begin
        hd[0] = x86enc_pkg::OPC_ENTER;
        hcnt  = 2'd1;
        tl[0] = req.frame_size[7:0];
        tl[1] = req.frame_size[15:8];
        tl[2] = req.nest_level;
        tcnt  = 4'd3;
      end
      x86enc_pkg::CMD_LEAVE: begin
        hd[0] = x86enc_pkg::OPC_LEAVE;
        hcnt  = 2'd1;
      end
      x86enc_pkg::CMD_PUSH: begin
        if (req.dest_kind == x86enc_pkg::KIND_IMM) begin
          hd[0] = x86enc_pkg::OPC_PUSH_IMM;
          hcnt  = 2'd1;
          for (int k = 0; k < 4; k++) tl[k] = req.immediate[8*k +: 8];
          tcnt  = 4'd4;
        end else begin
          use_rm = 1'b1;
          fixed  = 1'b1;
          regf   = x86enc_pkg::EXT_PUSH;
          opc0   = x86enc_pkg::OPC_GRP5;
        end
      end
      x86enc_pkg::CMD_POP: begin
        use_rm = 1'b1;
        fixed  = 1'b1;
        regf   = x86enc_pkg::EXT_ZERO;
        opc0   = x86enc_pkg::OPC_POP_RM;
      end
      default: begin
        hd[0] = x86enc_pkg::OPC_ESC;
        hd[1] = x86enc_pkg::OPC_SYSCALL;
        hcnt  = 2'd2;
      end
    endcase

    // Register-to-r/m forms pick the d bit by which side is a register.
    if (do_two) begin
      if (req.dest_kind == x86enc_pkg::KIND_REG) begin
        use_rm  = 1'b1;
        regf    = req.dest_reg;
        rm_kind = req.src_kind;
        rm_reg  = req.src_reg;
        rm_disp = req.src_disp;
        opc0    = base | 8'h02;
      end else if (req.src_kind == x86enc_pkg::KIND_REG) begin
        use_rm = 1'b1;
        regf   = req.src_reg;
        opc0   = base;
      end else begin
        err = 1'b1;
      end
    end

    if (use_rm) begin
      case (rm_kind)
        x86enc_pkg::KIND_REG: begin
          mod = 2'd3;
          rmf = rm_reg[2:0];
          rb  = rm_reg[3];
        end
        x86enc_pkg::KIND_ABS: begin
          mod     = 2'd0;
          rmf     = x86enc_pkg::RM_SIB;
          has_sib = 1'b1;
          sib     = x86enc_pkg::SIB_ABS;
          dsp_en  = 1'b1;
        end
        x86enc_pkg::KIND_RIP: begin
          mod    = 2'd0;
          rmf    = x86enc_pkg::RM_RIP;
          dsp_en = 1'b1;
        end
        x86enc_pkg::KIND_REGDISP: begin
          mod    = 2'd2;
          rmf    = rm_reg[2:0];
          rb     = rm_reg[3];
          dsp_en = 1'b1;
          // A stack-pointer style base needs an explicit SIB byte.
          if (rm_reg[2:0] == x86enc_pkg::RM_SIB) begin
            has_sib = 1'b1;
            sib     = x86enc_pkg::SIB_RSP;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      dsp     = rm_disp;
      has_rex = !fixed || regf[3] || rb || force_rex;
      rex     = x86enc_pkg::REX_BASE | {4'd0, !fixed, regf[3], 1'b0, rb};
      if (has_rex) begin
        hd[0] = rex;
        hd[1] = opc0;
        hd[2] = opc1;
      end else begin
        hd[0] = opc0;
        hd[1] = opc1;
      end
      hcnt  = {1'b0, has_rex} + {1'b0, two_opc} + 2'd1;
      md[0] = {mod, regf[2:0], rmf};
      md[1] = sib;
      mcnt  = has_sib ? 2'd2 : 2'd1;
    end
  end

  // Place the segments into the byte image at their running offsets.
  always_comb begin
    logic [4:0] o1;
    logic [4:0] o2;
    logic [4:0] o3;
    logic [4:0] total;
    logic [4:0] pos;
    logic [4:0] rel;

    o1    = {3'd0, hcnt};
    o2    = o1 + {3'd0, mcnt};
    o3    = o2 + (dsp_en ? 5'd4 : 5'd0);
    total = o3 + {1'b0, tcnt};
    enc   = '0;
    for (int i = 0; i < x86enc_pkg::MaxBytes; i++) begin
      pos = 5'(i);
      rel = '0;
      if (pos < o1) begin
        enc.bytes[i] = hd[pos[1:0]];
      end else if (pos < o2) begin
        rel          = pos - o1;
        enc.bytes[i] = md[rel[0]];
      end else if (pos < o3) begin
        rel          = pos - o2;
        enc.bytes[i] = dsp[{rel[1:0], 3'd0} +: 8];
      end else if (pos < total) begin
        rel          = pos - o3;
        enc.bytes[i] = tl[rel[2:0]];
      end
    end
    if (err) begin
      // An unsupported request collapses to one zero byte flagged as error.
      enc.bytes = '0;
      enc.len   = x86enc_pkg::LenW'(1);
      enc.err   = 1'b1;
    end else begin
      enc.len = total[x86enc_pkg::LenW-1:0];
    end
  end

endmodule

[hw/rtl/x86enc_serializer.sv]
// Result register and byte serializer: holds one encoded instruction and
// hands its bytes out one per accepted output cycle. Depends on x86enc_pkg.
module x86enc_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  x86enc_pkg::enc_t load_data,
  output logic             out_valid,
  input  logic             out_ready,
  output x86enc_pkg::rsp_t out_data
);

  logic                         busy;
  logic                         busy_next;
  x86enc_pkg::enc_t             held;
  logic [x86enc_pkg::IdxW-1:0]  idx;
  logic [x86enc_pkg::IdxW-1:0]  idx_next;
  logic                         is_last;
  logic                         take;
  logic                         load;

  assign is_last    = (x86enc_pkg::LenW'(idx) == held.len - x86enc_pkg::LenW'(1));
  assign take       = busy && out_ready;
  assign load_ready = !busy || (out_ready && is_last);
  assign load       = load_valid && load_ready;

  assign out_valid          = busy;
  assign out_data.code_byte = held.bytes[idx];
  assign out_data.last      = is_last;
  assign out_data.error     = held.err;

  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    if (load) begin
      busy_next = 1'b1;
      idx_next  = '0;
    end else if (take) begin
      if (is_last) begin
        busy_next = 1'b0;
      end else begin
        idx_next = idx + x86enc_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  // The byte pointer never runs past the held instruction.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (x86enc_pkg::LenW'(idx) < held.len))
    else $error("byte index beyond instruction length");

  // An error result is a single zero byte.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (busy && held.err) |-> (is_last && out_data.code_byte == 8'd0))
    else $error("error result is not a single zero byte");

  // Taking a byte that is not the last advances to the next byte.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> (busy && idx == $past(idx) + x86enc_pkg::IdxW'(1)))
    else $error("serializer failed to advance");

  // After the last byte leaves with nothing to load, the serializer idles.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && is_last && !load_valid) |=> !busy)
    else $error("serializer still busy after last byte");

  // A freshly loaded instruction starts at its first byte.
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && idx == '0))
    else $error("load did not restart at first byte");

endmodule

[hw/rtl/x86_64_instruction_encoder_unit.sv]
// Top level of the x86-64 instruction encoder: request register, encoder and
// byte serializer. Depends on x86enc_pkg, x86enc_core and x86enc_serializer.
//
//   Channel  Handshake              Payload            Moves
//   in       in_valid / in_ready    x86enc_pkg::req_t  one instruction request
//   out      out_valid / out_ready  x86enc_pkg::rsp_t  one machine code byte
//
// A request of n bytes (1 to 12; an unsupported request gives one error byte)
// leaves as n byte transfers on the output channel, which sets the sustained rate.
// An accepted request passes through the request register, where the encoder
// works, and then the serializer's result register, which emits its first byte.
// A new request is accepted while the previous one is still being emitted; the
// result register reloads in the same cycle its last byte is taken.
// A stalled output holds the current byte; the request register then fills and
// in_ready drops until the serializer can take the next encoded instruction.
// Reset (rst, synchronous) empties both registers; no output is valid after it.
module x86_64_instruction_encoder_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  x86enc_pkg::req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output x86enc_pkg::rsp_t out_data
);

  // Request register in front of the combinational encoder.
  logic             q_valid;
  x86enc_pkg::req_t q_req;
  x86enc_pkg::enc_t enc;
  logic             ld_ready;

  // The request register can take a new request when it is empty or when its
  // current contents move into the serializer this cycle.
  assign in_ready = !q_valid || ld_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_req <= in_data;
    end
  end

  // Encoding happens entirely between the request register and the serializer.
  x86enc_core u_core (
    .req (q_req),
    .enc (enc)
  );

  x86enc_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (q_valid),
    .load_ready (ld_ready),
    .load_data  (enc),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[dv/x86_64_instruction_encoder_unit_tb.sv]
// Testbench for the x86-64 instruction encoder: drives requests and checks code bytes.
// Uses x86enc_pkg for the request and byte types and the encoding constants, and
// compares each emitted byte against an in-bench prediction of the encoding.
module x86_64_instruction_encoder_unit_tb;

  localparam int WatchdogLimit = 3000;  // cycles with no transfer before giving up
  localparam int LongHold      = 400;   // cycles of the receiver hold-off
  localparam int DrainCycles   = 8;     // slack after the expected bytes have drained
  localparam logic [7:0] DirBit     = 8'h02;  // d bit: register operand is the destination
  localparam logic [2:0] KindBad    = 3'd5;   // lowest undefined operand kind
  localparam logic [2:0] KindBadMax = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  reg_num;
    logic [31:0] disp;
  } operand_t;

  // Predicts the byte run of each accepted request and checks the bytes that come out.
  class encoding_scoreboard;
    x86enc_pkg::rsp_t pending[$];
    logic [7:0]       code[$];
    int               mismatches    = 0;
    int               bytes_checked = 0;
    int               error_results = 0;
    int               requests      = 0;

    function void emit8(logic [7:0] v);
      if (code.size() < x86enc_pkg::MaxBytes) code.push_back(v);
    endfunction

    function void emit16(logic [15:0] v);
      emit8(v[7:0]);
      emit8(v[15:8]);
    endfunction

    function void emit32(logic [31:0] v);
      emit16(v[15:0]);
      emit16(v[31:16]);
    endfunction

    // REX, opcode, ModRM, optional SIB and disp32; returns 0 if the r/m operand is unusable.
    function bit emit_rm(bit fixed_size, bit force_rex, logic [3:0] regf, operand_t rm,
                         logic [7:0] opc0, logic [7:0] opc1, bit two_byte_opc);
      logic [1:0] mod_f;
      logic [2:0] rm_f;
      logic [7:0] sib;
      bit         w, b, has_sib, has_disp;
      if (!(rm.kind == x86enc_pkg::KIND_REG || rm.kind == x86enc_pkg::KIND_ABS ||
            rm.kind == x86enc_pkg::KIND_RIP || rm.kind == x86enc_pkg::KIND_REGDISP))
        return 1'b0;
      w        = !fixed_size;
      b        = 1'b0;
      has_sib  = 1'b0;
      has_disp = 1'b1;
      sib      = x86enc_pkg::SIB_ABS;
      mod_f    = 2'b00;
      rm_f     = x86enc_pkg::RM_RIP;
      case (rm.kind)
        x86enc_pkg::KIND_REG: begin
          mod_f    = 2'b11;
          rm_f     = rm.reg_num[2:0];
          b        = rm.reg_num[3];
          has_disp = 1'b0;
        end
        x86enc_pkg::KIND_ABS: begin
          rm_f    = x86enc_pkg::RM_SIB;
          has_sib = 1'b1;
          sib     = x86enc_pkg::SIB_ABS;
        end
        x86enc_pkg::KIND_RIP: begin
          rm_f = x86enc_pkg::RM_RIP;
        end
        default: begin
          mod_f = 2'b10;
          rm_f  = rm.reg_num[2:0];
          b     = rm.reg_num[3];
          // A base with low bits 100 is the SIB escape, so rsp and r12 need SIB 0x24.
          if (rm_f == x86enc_pkg::RM_SIB) begin
            has_sib = 1'b1;
            sib     = x86enc_pkg::SIB_RSP;
          end
        end
      endcase
      if (w || regf[3] || b || force_rex)
        emit8(x86enc_pkg::REX_BASE | {4'b0000, w, regf[3], 1'b0, b});
      emit8(opc0);
      if (two_byte_opc) emit8(opc1);
      emit8({mod_f, regf[2:0], rm_f});
      if (has_sib) emit8(sib);
      if (has_disp) emit32(rm.disp);
      return 1'b1;
    endfunction

    // Register-to-r/m forms: the register side picks the direction bit.
    function bit emit_reg_rm(operand_t dst, operand_t src, logic [7:0] base_opc);
      if (dst.kind == x86enc_pkg::KIND_REG) return emit_rm(1'b0, 1'b0, dst.reg_num, src,
                                                           base_opc | DirBit, 8'h00, 1'b0);
      if (src.kind == x86enc_pkg::KIND_REG) return emit_rm(1'b0, 1'b0, src.reg_num, dst,
                                                           base_opc, 8'h00, 1'b0);
      return 1'b0;
    endfunction

    function void note_request(x86enc_pkg::req_t q);
      operand_t         dst, src;
      bit               ok;
      x86enc_pkg::rsp_t e;
      dst.kind    = q.dest_kind;
      dst.reg_num = q.dest_reg;
      dst.disp    = q.dest_disp;
      src.kind    = q.src_kind;
      src.reg_num = q.src_reg;
      src.disp    = q.src_disp;
      code.delete();
      ok = 1'b1;
      requests++;
      case (q.command)
        x86enc_pkg::CMD_ADD, x86enc_pkg::CMD_SUB: begin
          if (src.kind == x86enc_pkg::KIND_IMM) begin
            ok = emit_rm(1'b0, 1'b0,
                         (q.command == x86enc_pkg::CMD_ADD) ? x86enc_pkg::EXT_ADD
                                                            : x86enc_pkg::EXT_SUB,
                         dst, x86enc_pkg::OPC_GRP1_IMM, 8'h00, 1'b0);
            if (ok) emit32(q.immediate[31:0]);
          end else begin
            ok = emit_reg_rm(dst, src,
                             (q.command == x86enc_pkg::CMD_ADD) ? x86enc_pkg::OPC_ADD
                                                                : x86enc_pkg::OPC_SUB);
          end
        end
        x86enc_pkg::CMD_MUL, x86enc_pkg::CMD_DIV: begin
          ok = emit_rm(1'b0, 1'b0,
                       (q.command == x86enc_pkg::CMD_MUL) ? x86enc_pkg::EXT_MUL
                                                          : x86enc_pkg::EXT_DIV,
                       dst, x86enc_pkg::OPC_GRP3, 8'h00, 1'b0);
        end
        x86enc_pkg::CMD_MOV: begin
          if (src.kind == x86enc_pkg::KIND_IMM) begin
            if (dst.kind == x86enc_pkg::KIND_REG) begin
              emit8(x86enc_pkg::REX_W | {7'b0, dst.reg_num[3]});
              emit8(x86enc_pkg::OPC_MOV_IMM | {5'b0, dst.reg_num[2:0]});
              emit32(q.immediate[31:0]);
              emit32(q.immediate[63:32]);
            end else begin
              ok = 1'b0;
            end
          end else begin
            ok = emit_reg_rm(dst, src, x86enc_pkg::OPC_MOV);
          end
        end
        x86enc_pkg::CMD_CMP: begin
          if (dst.kind == x86enc_pkg::KIND_REG && src.kind == x86enc_pkg::KIND_IMM) begin
            emit8(x86enc_pkg::REX_W | {7'b0, dst.reg_num[3]});
            emit8(x86enc_pkg::OPC_GRP1_IMM);
            emit8(x86enc_pkg::MODRM_CMP_RI | {5'b0, dst.reg_num[2:0]});
            emit32(q.immediate[31:0]);
          end else begin
            ok = emit_reg_rm(dst, src, x86enc_pkg::OPC_CMP);
          end
        end
        x86enc_pkg::CMD_SETCC: begin
          // Byte-sized, so REX is always present to reach sil/dil and friends.
          ok = emit_rm(1'b1, 1'b1, x86enc_pkg::EXT_ZERO, dst, x86enc_pkg::OPC_ESC,
                       x86enc_pkg::OPC_SETCC | {4'b0, q.cond_code}, 1'b1);
        end
        x86enc_pkg::CMD_JMP, x86enc_pkg::CMD_CALL: begin
          if (dst.kind == x86enc_pkg::KIND_RIP) begin
            emit8((q.command == x86enc_pkg::CMD_JMP) ? x86enc_pkg::OPC_JMP_REL
                                                     : x86enc_pkg::OPC_CALL_REL);
            emit32(dst.disp);
          end else begin
            ok = emit_rm(1'b1, 1'b0,
                         (q.command == x86enc_pkg::CMD_JMP) ? x86enc_pkg::EXT_JMP
                                                            : x86enc_pkg::EXT_CALL,
                         dst, x86enc_pkg::OPC_GRP5, 8'h00, 1'b0);
          end
        end
        x86enc_pkg::CMD_JCC: begin
          emit8(x86enc_pkg::OPC_ESC);
          emit8(x86enc_pkg::OPC_JCC | {4'b0, q.cond_code});
          emit32(q.branch_disp);
        end
        x86enc_pkg::CMD_RET: begin
          if (q.frame_size == 16'h0) begin
            emit8(x86enc_pkg::OPC_RET);
          end else begin
            emit8(x86enc_pkg::OPC_RET_IMM);
            emit16(q.frame_size);
          end
        end
        x86enc_pkg::CMD_ENTER: begin
          emit8(x86enc_pkg::OPC_ENTER);
          emit16(q.frame_size);
          emit8(q.nest_level);
        end
        x86enc_pkg::CMD_LEAVE: begin
          emit8(x86enc_pkg::OPC_LEAVE);
        end
        x86enc_pkg::CMD_PUSH: begin
          if (dst.kind == x86enc_pkg::KIND_IMM) begin
            emit8(x86enc_pkg::OPC_PUSH_IMM);
            emit32(q.immediate[31:0]);
          end else begin
            ok = emit_rm(1'b1, 1'b0, x86enc_pkg::EXT_PUSH, dst, x86enc_pkg::OPC_GRP5,
                         8'h00, 1'b0);
          end
        end
        x86enc_pkg::CMD_POP: begin
          ok = emit_rm(1'b1, 1'b0, x86enc_pkg::EXT_ZERO, dst, x86enc_pkg::OPC_POP_RM,
                       8'h00, 1'b0);
        end
        default: begin
          emit8(x86enc_pkg::OPC_ESC);
          emit8(x86enc_pkg::OPC_SYSCALL);
        end
      endcase
      if (!ok || code.size() == 0) begin
        e.code_byte = 8'h00;
        e.last      = 1'b1;
        e.error     = 1'b1;
        pending.push_back(e);
        error_results++;
      end else begin
        foreach (code[i]) begin
          e.code_byte = code[i];
          e.last      = (i == code.size() - 1);
          e.error     = 1'b0;
          pending.push_back(e);
        end
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_byte(x86enc_pkg::rsp_t got);
      x86enc_pkg::rsp_t want;
      bytes_checked++;
      if (pending.size() == 0) begin
        report($sformatf("byte %0d (%02h) arrived with nothing pending",
                         bytes_checked, got.code_byte));
        return;
      end
      want = pending.pop_front();
      if (got.code_byte !== want.code_byte)
        report($sformatf("byte %0d: code_byte %02h, expected %02h",
                         bytes_checked, got.code_byte, want.code_byte));
      if (got.last !== want.last)
        report($sformatf("byte %0d: last %b, expected %b", bytes_checked, got.last, want.last));
      if (got.error !== want.error)
        report($sformatf("byte %0d: error %b, expected %b",
                         bytes_checked, got.error, want.error));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  x86enc_pkg::req_t in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  x86enc_pkg::rsp_t out_data;

  encoding_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit want_hold     = 1'b0;  // raised by the stimulus, serviced once by the receiver
  bit held_off      = 1'b0;
  int idle_cycles   = 0;
  int directed      = 0;

  x86_64_instruction_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: random backpressure, plus one long hold-off on request.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (!rst && want_hold && !held_off) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        held_off = 1'b1;
      end
      out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_byte(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d bytes still pending",
                 WatchdogLimit, sb.pending.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly defined operand kinds, a register most often, now and then an undefined one.
  function automatic logic [2:0] pick_kind();
    int unsigned roll = $urandom_range(99);
    if (roll < 40) return x86enc_pkg::KIND_REG;
    if (roll < 52) return x86enc_pkg::KIND_IMM;
    if (roll < 64) return x86enc_pkg::KIND_ABS;
    if (roll < 76) return x86enc_pkg::KIND_RIP;
    if (roll < 94) return x86enc_pkg::KIND_REGDISP;
    return 3'($urandom_range(KindBadMax, KindBad));
  endfunction

  function automatic x86enc_pkg::req_t random_request();
    x86enc_pkg::req_t q;
    q.command     = 4'($urandom_range(15));
    q.dest_kind   = pick_kind();
    q.dest_reg    = 4'($urandom_range(15));
    q.dest_disp   = pick_word();
    q.src_kind    = pick_kind();
    q.src_reg     = 4'($urandom_range(15));
    q.src_disp    = pick_word();
    q.immediate   = {pick_word(), pick_word()};
    q.cond_code   = 4'($urandom_range(15));
    q.branch_disp = pick_word();
    case ($urandom_range(7))
      0, 1: q.frame_size = 16'h0000;
      2: q.frame_size = 16'hFFFF;
      default: q.frame_size = 16'($urandom_range(65535));
    endcase
    q.nest_level  = 8'($urandom_range(255));
    return q;
  endfunction

  // Directed request: the named fields are fixed, every other field carries noise.
  function automatic x86enc_pkg::req_t mk(logic [3:0] cmd,
                                          logic [2:0] dk = x86enc_pkg::KIND_REG,
                                          logic [3:0] dr = 4'd0,
                                          logic [2:0] sk = x86enc_pkg::KIND_REG,
                                          logic [3:0] sr = 4'd0, logic [31:0] dd = 32'h0,
                                          logic [63:0] imm = 64'h0);
    x86enc_pkg::req_t q;
    q           = random_request();
    q.command   = cmd;
    q.dest_kind = dk;
    q.dest_reg  = dr;
    q.src_kind  = sk;
    q.src_reg   = sr;
    q.dest_disp = dd;
    q.immediate = imm;
    return q;
  endfunction

  // Offers one request, idling first at the current rate; returns at a falling edge.
  task automatic send_request(input x86enc_pkg::req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (!in_ready);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin : stimulus
    x86enc_pkg::req_t q;
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: register extension bits, SIB cases, every command, and the
    // unsupported operand combinations.
    send_request(mk(x86enc_pkg::CMD_ADD, x86enc_pkg::KIND_REG, 4'd15,
                    x86enc_pkg::KIND_REG, 4'd8));
    send_request(mk(x86enc_pkg::CMD_SUB, x86enc_pkg::KIND_REG, 4'd12,
                    x86enc_pkg::KIND_IMM, 4'd0, 32'h0, 64'hFFFF_FFFF_8000_0000));
    send_request(mk(x86enc_pkg::CMD_ADD, x86enc_pkg::KIND_REGDISP, 4'd4,
                    x86enc_pkg::KIND_REG, 4'd9, 32'h8000_0000));
    // r12 base with an immediate is the longest encoding: twelve bytes.
    send_request(mk(x86enc_pkg::CMD_SUB, x86enc_pkg::KIND_REGDISP, 4'd12,
                    x86enc_pkg::KIND_IMM, 4'd0, 32'hFFFF_FFFF, 64'h0000_0000_7FFF_FFFF));
    send_request(mk(x86enc_pkg::CMD_MUL, x86enc_pkg::KIND_ABS, 4'd3,
                    x86enc_pkg::KIND_REG, 4'd0, 32'h7FFF_FFFF));
    send_request(mk(x86enc_pkg::CMD_DIV, x86enc_pkg::KIND_RIP, 4'd0,
                    x86enc_pkg::KIND_REG, 4'd0, 32'h0000_0010));
    send_request(mk(x86enc_pkg::CMD_MOV, x86enc_pkg::KIND_REG, 4'd8,
                    x86enc_pkg::KIND_IMM, 4'd0, 32'h0, 64'h8000_0000_0000_0000));
    send_request(mk(x86enc_pkg::CMD_MOV, x86enc_pkg::KIND_REGDISP, 4'd5,
                    x86enc_pkg::KIND_IMM));
    send_request(mk(x86enc_pkg::CMD_MOV, x86enc_pkg::KIND_ABS, 4'd0,
                    x86enc_pkg::KIND_RIP));
    send_request(mk(x86enc_pkg::CMD_CMP, x86enc_pkg::KIND_REG, 4'd13,
                    x86enc_pkg::KIND_IMM, 4'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(mk(x86enc_pkg::CMD_CMP, x86enc_pkg::KIND_ABS, 4'd0,
                    x86enc_pkg::KIND_IMM));
    send_request(mk(x86enc_pkg::CMD_ADD, x86enc_pkg::KIND_REG, 4'd2, KindBad));
    q = mk(x86enc_pkg::CMD_SETCC, x86enc_pkg::KIND_REG, 4'd15);
    q.cond_code = 4'd15;
    send_request(q);
    q = mk(x86enc_pkg::CMD_SETCC, x86enc_pkg::KIND_REG, 4'd6);
    q.cond_code = 4'd0;
    send_request(q);
    send_request(mk(x86enc_pkg::CMD_JMP, x86enc_pkg::KIND_RIP, 4'd0,
                    x86enc_pkg::KIND_REG, 4'd0, 32'hFFFF_FFFF));
    send_request(mk(x86enc_pkg::CMD_CALL, x86enc_pkg::KIND_RIP, 4'd0,
                    x86enc_pkg::KIND_REG, 4'd0, 32'h8000_0000));
    q = mk(x86enc_pkg::CMD_JCC);
    q.cond_code   = 4'd15;
    q.branch_disp = 32'h7FFF_FFFF;
    send_request(q);
    q = mk(x86enc_pkg::CMD_RET);
    q.frame_size = 16'h0000;
    send_request(q);
    q.frame_size = 16'hFFFF;
    send_request(q);
    q = mk(x86enc_pkg::CMD_ENTER);
    q.frame_size = 16'hFFFF;
    q.nest_level = 8'hFF;
    send_request(q);
    send_request(mk(x86enc_pkg::CMD_LEAVE));
    send_request(mk(x86enc_pkg::CMD_SYSCALL));
    send_request(mk(x86enc_pkg::CMD_PUSH, x86enc_pkg::KIND_IMM, 4'd0,
                    x86enc_pkg::KIND_REG, 4'd0, 32'h0, 64'h0000_0000_8000_0000));
    send_request(mk(x86enc_pkg::CMD_PUSH, x86enc_pkg::KIND_REG, 4'd15));
    send_request(mk(x86enc_pkg::CMD_POP, x86enc_pkg::KIND_REGDISP, 4'd4,
                    x86enc_pkg::KIND_REG, 4'd0, 32'h0000_0001));
    send_request(mk(x86enc_pkg::CMD_POP, KindBadMax));
    directed = sb.requests;

    // Random part under three stall mixes.
    send_idle_pct = 12;
    recv_idle_pct = 72;
    send_random(145);
    send_idle_pct = 72;
    recv_idle_pct = 12;
    send_random(145);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The receiver now holds off for a long stretch while requests keep coming,
    // so both internal registers fill and in_ready drops.
    want_hold = 1'b1;
    send_random(40);
    send_random(105);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected bytes never arrived", sb.pending.size()));

    $display("Encoded %0d requests (%0d directed) into %0d checked bytes, %0d error results.",
             sb.requests, directed, sb.bytes_checked, sb.error_results);
    $display("Stall mixes: sender-heavy, receiver-heavy, a %0d-cycle hold-off, none; %0d %s",
             LongHold, sb.mismatches, "mismatches.");
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[x86_64_instruction_encoder_unit.f]
hw/rtl/x86enc_pkg.sv
hw/rtl/x86enc_core.sv
hw/rtl/x86enc_serializer.sv
hw/rtl/x86_64_instruction_encoder_unit.sv
dv/x86_64_instruction_encoder_unit_tb.sv
